// ===== rtl/core/sprl_pkg.sv =====
// Shared types and constants for the sorted packet retransmit list.
package sprl_pkg;

  // Number of stored entries, address width and count width.
  localparam int DEPTH = 16;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_POP    = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_OLDER    = 3'd1,
    STS_DUP      = 3'd2,
    STS_FULL     = 3'd3,
    STS_EMPTY    = 3'd4,
    STS_NOTFOUND = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_POP,
    ST_SHD_RD,
    ST_SHD_WR,
    ST_SHU_RD,
    ST_SHU_WR,
    ST_PUT,
    ST_DONE
  } state_t;

  // One stored entry.
  typedef struct packed {
    logic [31:0] id;
    logic [7:0]  ptype;
    logic [15:0] handle;
    logic [31:0] stamp;
  } entry_t;

  // One command handed to the sequencer.
  typedef struct packed {
    op_t    op;
    entry_t entry;
  } cmd_t;

  // Result of one command, with its completion flag.
  typedef struct packed {
    logic          done;
    status_t       status;
    logic          popped_valid;
    entry_t        popped;
    logic [CW-1:0] used;
  } result_t;

endpackage

// ===== rtl/core/sprl_store.sv =====
// Entry memory: one write port and one read port with registered read data.
module sprl_store (
  input  logic                 clk,
  input  logic                 we,
  input  logic [sprl_pkg::AW-1:0] waddr,
  input  sprl_pkg::entry_t     wdata,
  input  logic [sprl_pkg::AW-1:0] raddr,
  output sprl_pkg::entry_t     rdata
);
  import sprl_pkg::*;

  entry_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/sprl_seq.sv =====
// Sequencer that scans, shifts and updates the entry memory through one compare unit.
module sprl_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  sprl_pkg::cmd_t    cmd,
  input  logic              res_ready,
  output sprl_pkg::result_t res
);
  import sprl_pkg::*;

  state_t        state, state_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] pos, pos_next;
  status_t       status, status_next;
  logic          pvalid, pvalid_next;
  entry_t        pentry, pentry_next;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [AW-1:0] mem_raddr;
  entry_t        rdata;

  logic          id_lt, id_eq;
  logic [CW-1:0] idx_inc, idx_dec;
  logic          idx_last;
  logic          is_full;

  sprl_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  // Shared compare unit on the entry just read.
  assign id_lt    = rdata.id < cmd.entry.id;
  assign id_eq    = rdata.id == cmd.entry.id;
  assign idx_inc  = idx + CW'(1);
  assign idx_dec  = idx - CW'(1);
  assign idx_last = idx_inc == count;
  assign is_full  = count == CW'(DEPTH);

  // State and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      idx   <= '0;
      pos   <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      idx   <= idx_next;
      pos   <= pos_next;
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    status <= status_next;
    pvalid <= pvalid_next;
    pentry <= pentry_next;
  end

  // Next state, memory control and result updates.
  always_comb begin
    state_next  = state;
    idx_next    = idx;
    count_next  = count;
    pos_next    = pos;
    status_next = status;
    pvalid_next = pvalid;
    pentry_next = pentry;
    mem_we      = 1'b0;
    mem_waddr   = idx[AW-1:0];
    mem_wdata   = rdata;
    mem_raddr   = idx[AW-1:0];
    case (state)
      ST_IDLE: begin
        mem_raddr = '0;
        if (start) begin
          status_next = STS_OK;
          pvalid_next = 1'b0;
          pentry_next = '0;
          idx_next    = '0;
          case (cmd.op)
            OP_APPEND: begin
              if (is_full) begin
                status_next = STS_FULL;
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = count[AW-1:0];
                mem_wdata  = cmd.entry;
                count_next = count + CW'(1);
              end
              state_next = ST_DONE;
            end
            OP_INSERT: begin
              if (count == '0) begin
                pos_next   = '0;
                state_next = ST_PUT;
              end else begin
                state_next = ST_SCAN;
              end
            end
            OP_POP: begin
              if (count == '0) begin
                status_next = STS_EMPTY;
                state_next  = ST_DONE;
              end else begin
                state_next = ST_POP;
              end
            end
            OP_REMOVE: begin
              if (count == '0) begin
                status_next = STS_NOTFOUND;
                state_next  = ST_DONE;
              end else begin
                state_next = ST_SCAN;
              end
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end
      // One entry is compared per cycle while the next one is read.
      ST_SCAN: begin
        mem_raddr = idx_inc[AW-1:0];
        if (cmd.op == OP_INSERT) begin
          if (!id_lt) begin
            if (id_eq) begin
              status_next = STS_DUP;
              state_next  = ST_DONE;
            end else if (idx == '0) begin
              status_next = STS_OLDER;
              state_next  = ST_DONE;
            end else if (is_full) begin
              status_next = STS_FULL;
              state_next  = ST_DONE;
            end else begin
              pos_next   = idx;
              idx_next   = count;
              state_next = ST_SHU_RD;
            end
          end else if (idx_last) begin
            if (is_full) begin
              status_next = STS_FULL;
              state_next  = ST_DONE;
            end else begin
              pos_next   = count;
              state_next = ST_PUT;
            end
          end else begin
            idx_next = idx_inc;
          end
        end else begin
          if (id_eq) begin
            if (idx_last) begin
              count_next = count - CW'(1);
              state_next = ST_DONE;
            end else begin
              state_next = ST_SHD_RD;
            end
          end else if (idx_last) begin
            status_next = STS_NOTFOUND;
            state_next  = ST_DONE;
          end else begin
            idx_next = idx_inc;
          end
        end
      end
      // The head entry is on the read port.
      ST_POP: begin
        pvalid_next = 1'b1;
        pentry_next = rdata;
        if (count == CW'(1)) begin
          count_next = '0;
          state_next = ST_DONE;
        end else begin
          state_next = ST_SHD_RD;
        end
      end
      // Close a slot: move the entry behind idx one place toward the head.
      ST_SHD_RD: begin
        mem_raddr  = idx_inc[AW-1:0];
        state_next = ST_SHD_WR;
      end
      ST_SHD_WR: begin
        mem_we   = 1'b1;
        idx_next = idx_inc;
        if (idx + CW'(2) == count) begin
          count_next = count - CW'(1);
          state_next = ST_DONE;
        end else begin
          state_next = ST_SHD_RD;
        end
      end
      // Open a slot: move the entry in front of idx one place toward the tail.
      ST_SHU_RD: begin
        mem_raddr  = idx_dec[AW-1:0];
        state_next = ST_SHU_WR;
      end
      ST_SHU_WR: begin
        mem_we   = 1'b1;
        idx_next = idx_dec;
        if (idx_dec == pos) begin
          state_next = ST_PUT;
        end else begin
          state_next = ST_SHU_RD;
        end
      end
      ST_PUT: begin
        mem_we     = 1'b1;
        mem_waddr  = pos[AW-1:0];
        mem_wdata  = cmd.entry;
        count_next = count + CW'(1);
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign res.done         = state == ST_DONE;
  assign res.status       = status;
  assign res.popped_valid = pvalid;
  assign res.popped       = pentry;
  assign res.used         = count;

endmodule

// ===== rtl/core/sorted_packet_retransmit_list_unit.sv =====
// Top level of the sorted packet retransmit list.
//
//   channel | direction | handshake         | payload
//   in      | input     | in_valid/in_stall | op, packet_id, packet_type, payload_handle, now_time
//   out     | output    | out_valid/out_stall | status, popped_*, entries_used
//
// An append is written to memory once the registered start reaches the idle sequencer, and its
// result passes through the done state into the output register. Ordered insert and remove scan
// the entry memory one entry per cycle, and every entry that moves is read on the read port and
// then written back on the write port. Pop returns the head entry, then moves each remaining
// entry one place toward the head. Reset empties the list at once. A new transaction is taken as
// soon as the previous result sits in the output register, even while that result is stalled.
module sorted_packet_retransmit_list_unit (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              op,
  input  logic [31:0]             packet_id,
  input  logic [7:0]              packet_type,
  input  logic [15:0]             payload_handle,
  input  logic [31:0]             now_time,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [2:0]              status,
  output logic                    popped_valid,
  output logic [31:0]             popped_id,
  output logic [7:0]              popped_type,
  output logic [15:0]             popped_handle,
  output logic [31:0]             popped_time,
  output logic [sprl_pkg::CW-1:0] entries_used
);
  import sprl_pkg::*;

  logic    busy;
  logic    start;
  cmd_t    cmd;
  result_t res;
  result_t out_res;
  logic    res_ready;
  logic    in_accept;
  logic    res_load;

  assign in_stall  = busy;
  assign in_accept = in_valid && !busy;
  assign res_ready = !out_valid || !out_stall;
  assign res_load  = res.done && res_ready;

  sprl_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .res_ready (res_ready),
    .res       (res)
  );

  // Handshake control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      start     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      start <= in_accept;
      if (in_accept) begin
        busy <= 1'b1;
      end else if (res_load) begin
        busy <= 1'b0;
      end
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Command capture on an accepted transaction.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd.op           <= op_t'(op);
      cmd.entry.id     <= packet_id;
      cmd.entry.ptype  <= packet_type;
      cmd.entry.handle <= payload_handle;
      cmd.entry.stamp  <= now_time;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res <= res;
    end
  end

  assign status        = out_res.status;
  assign popped_valid  = out_res.popped_valid;
  assign popped_id     = out_res.popped.id;
  assign popped_type   = out_res.popped.ptype;
  assign popped_handle = out_res.popped.handle;
  assign popped_time   = out_res.popped.stamp;
  assign entries_used  = out_res.used;

endmodule

// ===== rtl/core/sprl_checker.sv =====
// Port-level checks for the sorted packet retransmit list, bound to the top level.
module sprl_checker (
  input logic                    clk,
  input logic                    rst,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [2:0]              status,
  input logic                    popped_valid,
  input logic [31:0]             popped_id,
  input logic [sprl_pkg::CW-1:0] entries_used
);
  import sprl_pkg::*;

  // A stalled result holds its status and count.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(entries_used))
    else $error("stalled result changed");

  // A returned entry always comes with an ok status.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && popped_valid |-> status == STS_OK)
    else $error("popped entry with non-ok status");

  // Without a returned entry the popped id reads zero.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !popped_valid |-> popped_id == '0)
    else $error("popped id not zero");

  // An empty report means the list holds nothing.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STS_EMPTY |-> entries_used == '0)
    else $error("empty status with stored entries");

  // A full report means the list is at capacity.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STS_FULL |-> entries_used == CW'(DEPTH))
    else $error("full status below capacity");

endmodule

bind sorted_packet_retransmit_list_unit sprl_checker u_sprl_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .status       (status),
  .popped_valid (popped_valid),
  .popped_id    (popped_id),
  .entries_used (entries_used)
);
